// ----- sv/rlb_pkg.sv -----
package rlb_pkg;

    localparam int CHAN_W  = 8;
    localparam int ALPHA_W = 9;
    localparam int NCHAN   = 3;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 9;

    localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd255;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_BLEND_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_OPACITY    = 2'd1;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_ADD      = 2'd1,
        MODE_MULTIPLY = 2'd2,
        MODE_SCREEN   = 2'd3
    } blend_mode_t;

    typedef logic [NCHAN-1:0][CHAN_W-1:0] pix_t;

    typedef struct packed {
        blend_mode_t         mode;
        logic [ALPHA_W-1:0]  alpha;
    } cfg_t;

    // blend value handed from the blend stages to the mix stages
    typedef struct packed {
        logic valid;
        pix_t bottom;
        pix_t blend;
    } mid_t;

    // floor(x / 255) for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
        logic [2*CHAN_W:0] t;
        t = {1'b0, x} + {9'd0, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
        return t[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

// ----- sv/rlb_ifs.sv -----
interface rlb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] bottom_red;
    logic [7:0] bottom_green;
    logic [7:0] bottom_blue;
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;

    modport source (
        output valid, bottom_red, bottom_green, bottom_blue, top_red, top_green, top_blue,
        input  ready
    );
    modport sink (
        input  valid, bottom_red, bottom_green, bottom_blue, top_red, top_green, top_blue,
        output ready
    );
endinterface

interface rlb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface rlb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/rlb_cfg_regs.sv -----
module rlb_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    rlb_cfg_if.sink        cfg,
    output rlb_pkg::cfg_t  cfg_state
);
    import rlb_pkg::*;

    blend_mode_t        mode_reg, mode_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        mode_next  = mode_reg;
        alpha_next = alpha_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BLEND_MODE: mode_next = blend_mode_t'(cfg.data[1:0]);
                // opacity above one is held as fully opaque
                REG_OPACITY:    alpha_next = (cfg.data > ALPHA_ONE) ? ALPHA_ONE : cfg.data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            alpha_reg <= ALPHA_ONE;
        end
        else
        begin
            mode_reg  <= mode_next;
            alpha_reg <= alpha_next;
        end
    end

    assign cfg_state.mode  = mode_reg;
    assign cfg_state.alpha = alpha_reg;

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        alpha_reg <= ALPHA_ONE)
        else $error("opacity weight above one");

endmodule

// ----- sv/rlb_blend.sv -----
module rlb_blend (
    input  logic           clk,
    input  logic           rst_n,
    input  rlb_pkg::cfg_t  cfg_state,
    rlb_in_if.sink         pix_in,
    output rlb_pkg::mid_t  mid,
    input  logic           mid_ready
);
    import rlb_pkg::*;

    // stage 1: raw product and sum
    logic                  v1_reg;
    pix_t                  b1_reg, t1_reg;
    logic [NCHAN-1:0][2*CHAN_W-1:0] prod1_reg, prod1_next;
    logic [NCHAN-1:0][CHAN_W:0]     sum1_reg, sum1_next;
    pix_t                  b_in, t_in;

    // stage 2: blend value
    logic                  v2_reg;
    pix_t                  b2_reg, x2_reg, x2_next;

    logic adv1, adv2;

    assign adv2 = !v2_reg || mid_ready;
    assign adv1 = !v1_reg || adv2;
    assign pix_in.ready = adv1;

    assign b_in = {pix_in.bottom_blue, pix_in.bottom_green, pix_in.bottom_red};
    assign t_in = {pix_in.top_blue, pix_in.top_green, pix_in.top_red};

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            sum1_next[c] = {1'b0, b_in[c]} + {1'b0, t_in[c]};
            // screen works on the complements, 255-v is ~v
            if (cfg_state.mode == MODE_SCREEN)
                prod1_next[c] = {{CHAN_W{1'b0}}, ~b_in[c]} * {{CHAN_W{1'b0}}, ~t_in[c]};
            else
                prod1_next[c] = 16'(b_in[c]) * 16'(t_in[c]);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            unique case (cfg_state.mode)
                MODE_NORMAL:   x2_next[c] = t1_reg[c];
                MODE_ADD:      x2_next[c] = sum1_reg[c][CHAN_W] ? CHAN_MAX
                                                                : sum1_reg[c][CHAN_W-1:0];
                MODE_MULTIPLY: x2_next[c] = div255(prod1_reg[c]);
                MODE_SCREEN:   x2_next[c] = ~div255(prod1_reg[c]);
                default:       x2_next[c] = t1_reg[c];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= pix_in.valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            b1_reg    <= b_in;
            t1_reg    <= t_in;
            prod1_reg <= prod1_next;
            sum1_reg  <= sum1_next;
        end
        if (adv2)
        begin
            b2_reg <= b1_reg;
            x2_reg <= x2_next;
        end
    end

    assign mid.valid  = v2_reg;
    assign mid.bottom = b2_reg;
    assign mid.blend  = x2_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !mid_ready) |=> (v2_reg && $stable(x2_reg) && $stable(b2_reg)))
        else $error("blend stage lost a stalled item");

    a_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv2 && cfg_state.mode == MODE_NORMAL) |=> (x2_reg == $past(t1_reg)))
        else $error("normal mode does not pass the top pixel");

    a_add: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv2 && cfg_state.mode == MODE_ADD) |=>
        (x2_reg[0] >= $past(b1_reg[0]) && x2_reg[0] >= $past(t1_reg[0])))
        else $error("add mode result below an operand");

endmodule

// ----- sv/rlb_mix.sv -----
module rlb_mix (
    input  logic           clk,
    input  logic           rst_n,
    input  rlb_pkg::cfg_t  cfg_state,
    input  rlb_pkg::mid_t  mid,
    output logic           mid_ready,
    rlb_out_if.source      pix_out
);
    import rlb_pkg::*;

    // stage 3: weighted products
    logic                           v3_reg;
    logic [NCHAN-1:0][2*CHAN_W-1:0] pb3_reg, px3_reg, pb3_next, px3_next;
    logic [ALPHA_W-1:0]             inv_alpha;
    logic [NCHAN-1:0][2*CHAN_W:0]   pb_full, px_full;

    // stage 4: output register
    logic                           v4_reg;
    pix_t                           o4_reg, o4_next;
    logic [NCHAN-1:0][2*CHAN_W:0]   mix_sum;

    logic adv3, adv4;

    assign adv4 = !v4_reg || pix_out.ready;
    assign adv3 = !v3_reg || adv4;
    assign mid_ready = adv3;

    assign inv_alpha = ALPHA_ONE - cfg_state.alpha;

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            pb_full[c]  = 17'(mid.bottom[c]) * 17'(inv_alpha);
            px_full[c]  = 17'(mid.blend[c]) * 17'(cfg_state.alpha);
            // each product stays within 255*256
            pb3_next[c] = pb_full[c][2*CHAN_W-1:0];
            px3_next[c] = px_full[c][2*CHAN_W-1:0];
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            mix_sum[c] = {1'b0, pb3_reg[c]} + {1'b0, px3_reg[c]};
            o4_next[c] = mix_sum[c][2*CHAN_W-1:CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
                v3_reg <= mid.valid;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            pb3_reg <= pb3_next;
            px3_reg <= px3_next;
        end
        if (adv4)
            o4_reg <= o4_next;
    end

    assign pix_out.valid     = v4_reg;
    assign pix_out.out_red   = o4_reg[0];
    assign pix_out.out_green = o4_reg[1];
    assign pix_out.out_blue  = o4_reg[2];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !adv4) |=> (v3_reg && $stable(pb3_reg) && $stable(px3_reg)))
        else $error("mix stage lost a stalled item");

    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (mid.valid && adv3 && cfg_state.alpha == ALPHA_ONE) |=> (pb3_reg[0] == 16'd0))
        else $error("bottom weight not zero at full opacity");

endmodule

// ----- sv/rgb_layer_blend.sv -----
// channel   | dir | handshake       | payload
// ----------+-----+-----------------+------------------------------------------
// pix_in    | in  | valid / ready   | bottom_red/green/blue, top_red/green/blue
// pix_out   | out | valid / ready   | out_red, out_green, out_blue
// cfg       | in  | valid / ready   | index (0 blend_mode, 1 opacity), data
//
// four register stages: product/sum, divide by 255 and mode select, weighted
//   products, final add and output register; one item per clock while pix_out is ready
// every stage holds its own valid bit and advances when empty or when the next one moves
// an item waiting at the output does not block intake while earlier stages have room
// reset clears the valid bits and sets blend_mode to normal, opacity to fully opaque
// cfg is always ready; opacity above one is stored as fully opaque
module rgb_layer_blend (
    input  logic       clk,
    input  logic       rst_n,
    rlb_in_if.sink     pix_in,
    rlb_out_if.source  pix_out,
    rlb_cfg_if.sink    cfg
);
    import rlb_pkg::*;

    // mode and clamped opacity shared by the blend and mix halves
    cfg_t cfg_state;
    // blend value and bottom pixel between the blend and mix halves
    mid_t mid;
    logic mid_ready;

    rlb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    // stages one and two: per channel blend value under the mode
    rlb_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_state (cfg_state),
        .pix_in    (pix_in),
        .mid       (mid),
        .mid_ready (mid_ready)
    );

    // stages three and four: (bottom*(256-a) + blend*a) >> 8
    rlb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_state (cfg_state),
        .mid       (mid),
        .mid_ready (mid_ready),
        .pix_out   (pix_out)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import rlb_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;       // pipeline is four deep, leave some slack
    localparam int CYCLE_LIMIT  = 100000;
    localparam int ITEMS_PER_SETTING = 50;
    localparam int NUM_SETTINGS      = 15;

    // one input item: bottom and top pixel, index 0 red, 1 green, 2 blue
    typedef struct {
        pix_t bottom;
        pix_t top;
    } layer_pair_t;

    logic clk;
    logic rst_n;

    rlb_in_if  pix_if ();
    rlb_out_if res_if ();
    rlb_cfg_if cfg_if ();

    rgb_layer_blend u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_if),
        .pix_out (res_if),
        .cfg     (cfg_if)
    );

    // items waiting to be offered, and blended pixels still to come out
    layer_pair_t pending_pairs[$];
    pix_t        pixels_due[$];

    // local copy of the register file
    blend_mode_t      cur_mode;
    logic [8:0]       cur_opacity;

    int  src_idle_pct;
    int  snk_idle_pct;
    int  mismatches;
    int  cycle_cnt;
    bit  pix_fire;       // input item taken at the last rising edge

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // blend one channel under the current mode, then mix by opacity
    function automatic logic [7:0] blend_chan(input logic [7:0] b, input logic [7:0] t);
        int unsigned bv;
        int unsigned tv;
        int unsigned bl;
        int unsigned a;
        int unsigned acc;
        bv = b;
        tv = t;
        // opacity past one counts as fully opaque
        a  = (cur_opacity > ALPHA_ONE) ? ALPHA_ONE : cur_opacity;
        case (cur_mode)
            MODE_ADD:      bl = (bv + tv > 255) ? 255 : bv + tv;
            MODE_MULTIPLY: bl = (bv * tv) / 255;
            MODE_SCREEN:   bl = 255 - ((255 - bv) * (255 - tv)) / 255;
            default:       bl = tv;
        endcase
        acc = bv * (256 - a) + bl * a;
        return acc[15:8];
    endfunction

    function automatic pix_t blend_pixel(input pix_t b, input pix_t t);
        pix_t r;
        for (int c = 0; c < NCHAN; c++)
            r[c] = blend_chan(b[c], t[c]);
        return r;
    endfunction

    // random channel value, leaning a little on the ends of the range
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        // hold an offered item until it is taken
        if (!(pix_if.valid && !pix_fire))
        begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                pix_if.valid        <= 1'b1;
                pix_if.bottom_red   <= pending_pairs[0].bottom[0];
                pix_if.bottom_green <= pending_pairs[0].bottom[1];
                pix_if.bottom_blue  <= pending_pairs[0].bottom[2];
                pix_if.top_red      <= pending_pairs[0].top[0];
                pix_if.top_green    <= pending_pairs[0].top[1];
                pix_if.top_blue     <= pending_pairs[0].top[2];
            end
            else
            begin
                pix_if.valid <= 1'b0;
            end
        end
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // monitor: both handshakes sampled on the rising edge
    always @(posedge clk)
    begin
        pix_t b;
        pix_t t;
        pix_t got;
        pix_t want;
        string names[NCHAN];
        names = '{"out_red", "out_green", "out_blue"};

        pix_fire = rst_n && pix_if.valid && pix_if.ready;
        if (pix_fire)
        begin
            b = {pix_if.bottom_blue, pix_if.bottom_green, pix_if.bottom_red};
            t = {pix_if.top_blue, pix_if.top_green, pix_if.top_red};
            pixels_due = {pixels_due, blend_pixel(b, t)};
            void'(pending_pairs.pop_front());
        end

        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = {res_if.out_blue, res_if.out_green, res_if.out_red};
            if (pixels_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item, expected none, actual %h", $time, got);
            end
            else
            begin
                want = pixels_due.pop_front();
                for (int c = 0; c < NCHAN; c++)
                begin
                    if (got[c] !== want[c])
                    begin
                        mismatches++;
                        $display("%0t: %s expected %0d, actual %0d",
                                 $time, names[c], want[c], got[c]);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // wait until every item is through, then let the pipeline settle
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || pixels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == REG_BLEND_MODE)
            cur_mode = blend_mode_t'(val[1:0]);
        else
            cur_opacity = val;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_setting(input blend_mode_t mode, input logic [8:0] alpha);
        wait_drained();
        cfg_write(REG_BLEND_MODE, DATA_W'(mode));
        cfg_write(REG_OPACITY, alpha);
    endtask

    task automatic push_pair(input pix_t b, input pix_t t);
        layer_pair_t p;
        p.bottom = b;
        p.top    = t;
        pending_pairs = {pending_pairs, p};
    endtask

    // black and white corners on every channel
    task automatic push_corners();
        push_pair({3{8'd0}},   {3{8'd0}});
        push_pair({3{8'd255}}, {3{8'd255}});
        push_pair({3{8'd0}},   {3{8'd255}});
        push_pair({3{8'd255}}, {3{8'd0}});
    endtask

    // channels differing from each other, near the middle and the ends
    task automatic push_mixed();
        push_pair({8'd1, 8'd128, 8'd255}, {8'd254, 8'd127, 8'd0});
        push_pair({8'd254, 8'd127, 8'd0}, {8'd1, 8'd128, 8'd255});
    endtask

    task automatic push_random(input int n);
        pix_t b;
        pix_t t;
        for (int i = 0; i < n; i++)
        begin
            for (int c = 0; c < NCHAN; c++)
            begin
                b[c] = rand_chan();
                t[c] = rand_chan();
            end
            push_pair(b, t);
        end
    endtask

    initial
    begin
        blend_mode_t set_mode[NUM_SETTINGS];
        logic [8:0]  set_alpha[NUM_SETTINGS];

        // every input known from time zero
        rst_n               = 1'b0;
        pix_if.valid        = 1'b0;
        pix_if.bottom_red   = '0;
        pix_if.bottom_green = '0;
        pix_if.bottom_blue  = '0;
        pix_if.top_red      = '0;
        pix_if.top_green    = '0;
        pix_if.top_blue     = '0;
        res_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        cur_mode            = MODE_NORMAL;
        cur_opacity         = ALPHA_ONE;
        mismatches          = 0;
        cycle_cnt           = 0;
        pix_fire            = 1'b0;
        src_idle_pct        = 21;
        snk_idle_pct        = 46;

        // register settings for the random part: fixed ones, with every second one from index 7 on drawn at random
        set_mode  = '{MODE_NORMAL, MODE_ADD, MODE_MULTIPLY, MODE_SCREEN, MODE_ADD,
                      MODE_MULTIPLY, MODE_SCREEN, MODE_NORMAL, MODE_ADD, MODE_SCREEN,
                      MODE_MULTIPLY, MODE_NORMAL, MODE_ADD, MODE_SCREEN, MODE_MULTIPLY};
        set_alpha = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd255,
                      9'd128, 9'd257, 9'd64, 9'd300, 9'd192,
                      9'd0, 9'd200, 9'd256, 9'd0, 9'd256};
        for (int i = 7; i < NUM_SETTINGS; i += 2)
        begin
            set_mode[i]  = blend_mode_t'($urandom_range(3));
            set_alpha[i] = 9'($urandom_range(511));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings first, no register write
        push_corners();
        push_pair({8'd1, 8'd128, 8'd255}, {8'd254, 8'd127, 8'd0});

        // add, multiply and screen, each fully opaque
        apply_setting(MODE_ADD, ALPHA_ONE);
        push_corners();
        apply_setting(MODE_MULTIPLY, ALPHA_ONE);
        push_corners();
        apply_setting(MODE_SCREEN, ALPHA_ONE);
        push_corners();

        // fully transparent, opacity past one, half weight
        apply_setting(MODE_NORMAL, 9'd0);
        push_mixed();
        apply_setting(MODE_SCREEN, 9'd511);
        push_mixed();
        apply_setting(MODE_ADD, 9'd128);
        push_mixed();

        // random part, idling swapped between sender and receiver, then none
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            if (s == NUM_SETTINGS / 3)
            begin
                wait_drained();
                src_idle_pct = 46;
                snk_idle_pct = 21;
            end
            else if (s == 2 * NUM_SETTINGS / 3)
            begin
                wait_drained();
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            apply_setting(set_mode[s], set_alpha[s]);
            push_random(ITEMS_PER_SETTING);
        end

        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rlb_pkg.sv
sv/rlb_ifs.sv
sv/rlb_cfg_regs.sv
sv/rlb_blend.sv
sv/rlb_mix.sv
sv/rgb_layer_blend.sv
tb/sv/tb.sv
